/* rtl/biquad_cascade_equalizer_macros.svh */
// ----------------------------------------------------------------------------
// biquad cascade equalizer assertion macros
// concurrent check helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef BIQUAD_CASCADE_EQUALIZER_MACROS_SVH
`define BIQUAD_CASCADE_EQUALIZER_MACROS_SVH

`ifndef SYNTH
`define BQEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BQEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BQEQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BQEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/bqeq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqeq_pkg
// shared types, codes and defaults of the biquad cascade equalizer
// ----------------------------------------------------------------------------
package bqeq_pkg;

    localparam int DEF_BANDS          = 10;
    localparam int DEF_CHANNELS       = 2;
    localparam int DEF_COEF_FRAC_BITS = 28;
    localparam int NCOEF              = 5;

    localparam logic [15:0] GAIN_RESET = 16'd16384;

    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_GAIN   = 1'b1;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    localparam logic [2:0] COEF_B0 = 3'd0;
    localparam logic [2:0] COEF_B1 = 3'd1;
    localparam logic [2:0] COEF_B2 = 3'd2;
    localparam logic [2:0] COEF_A1 = 3'd3;
    localparam logic [2:0] COEF_A2 = 3'd4;

    localparam logic [2:0] STEP_B0 = 3'd0;
    localparam logic [2:0] STEP_B1 = 3'd1;
    localparam logic [2:0] STEP_A1 = 3'd2;
    localparam logic [2:0] STEP_B2 = 3'd3;
    localparam logic [2:0] STEP_A2 = 3'd4;

    localparam logic [1:0] ACC_Q_Z1 = 2'd0;
    localparam logic [1:0] ACC_Q_Z2 = 2'd1;
    localparam logic [1:0] ACC_SUB  = 2'd2;
    localparam logic [1:0] ACC_Q    = 2'd3;

    typedef struct packed {
        logic               req_type;
        logic               channel;
        logic signed [15:0] sample_in;
        logic [3:0]         band_index;
        logic [2:0]         coef_select;
        logic signed [31:0] coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               channel_out;
    } out_item_t;

    typedef struct packed {
        logic       coef_wr;
        logic       take;
        logic       gain_ld;
        logic       band_clr;
        logic       band_inc;
        logic       z_rd;
        logic       z_k;
        logic       z_cap1;
        logic       z_cap2;
        logic       coef_rd;
        logic [2:0] coef_sel;
        logic       x_o;
        logic       mul_lo;
        logic       mul_hi;
        logic       comb;
        logic       acc_en;
        logic [1:0] acc_op;
        logic       o_ld;
        logic       z_wr;
        logic       s_adv;
        logic       out_ld;
    } cmd_t;

    typedef struct packed {
        logic in_req;
        logic in_pass;
        logic last_band;
        logic out_busy;
    } stat_t;

endpackage

/* rtl/bqeq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqeq_ctrl
// sequencer stepping bands and multiply-accumulate steps of each beat
// ----------------------------------------------------------------------------
module bqeq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  bqeq_pkg::stat_t stat,
    output bqeq_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GAIN = 4'd1;
    localparam logic [3:0] S_ZR1  = 4'd2;
    localparam logic [3:0] S_ZR2  = 4'd3;
    localparam logic [3:0] S_ZR3  = 4'd4;
    localparam logic [3:0] S_CRD  = 4'd5;
    localparam logic [3:0] S_MLO  = 4'd6;
    localparam logic [3:0] S_MHI  = 4'd7;
    localparam logic [3:0] S_COMB = 4'd8;
    localparam logic [3:0] S_ACC  = 4'd9;
    localparam logic [3:0] S_WB   = 4'd10;
    localparam logic [3:0] S_BEND = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic       uses_o;

    assign in_stall = (state_reg != S_IDLE);
    assign uses_o   = (step_reg == bqeq_pkg::STEP_A1) || (step_reg == bqeq_pkg::STEP_A2);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.x_o    = uses_o;
        case (step_reg)
            bqeq_pkg::STEP_B0: cmd.coef_sel = bqeq_pkg::COEF_B0;
            bqeq_pkg::STEP_B1: cmd.coef_sel = bqeq_pkg::COEF_B1;
            bqeq_pkg::STEP_A1: cmd.coef_sel = bqeq_pkg::COEF_A1;
            bqeq_pkg::STEP_B2: cmd.coef_sel = bqeq_pkg::COEF_B2;
            default:           cmd.coef_sel = bqeq_pkg::COEF_A2;
        endcase
        case (step_reg)
            bqeq_pkg::STEP_B0: cmd.acc_op = bqeq_pkg::ACC_Q_Z1;
            bqeq_pkg::STEP_B1: cmd.acc_op = bqeq_pkg::ACC_Q_Z2;
            bqeq_pkg::STEP_B2: cmd.acc_op = bqeq_pkg::ACC_Q;
            default:           cmd.acc_op = bqeq_pkg::ACC_SUB;
        endcase
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.in_req)
                    begin
                        cmd.coef_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.take     = 1'b1;
                        cmd.band_clr = 1'b1;
                        state_next   = stat.in_pass ? S_DONE : S_GAIN;
                    end
                end
            end
            S_GAIN:
            begin
                cmd.gain_ld = 1'b1;
                state_next  = S_ZR1;
            end
            S_ZR1:
            begin
                cmd.z_rd   = 1'b1;
                cmd.z_k    = 1'b0;
                state_next = S_ZR2;
            end
            S_ZR2:
            begin
                cmd.z_rd   = 1'b1;
                cmd.z_k    = 1'b1;
                cmd.z_cap1 = 1'b1;
                state_next = S_ZR3;
            end
            S_ZR3:
            begin
                cmd.z_cap2 = 1'b1;
                step_next  = bqeq_pkg::STEP_B0;
                state_next = S_CRD;
            end
            S_CRD:
            begin
                cmd.coef_rd = 1'b1;
                state_next  = S_MLO;
            end
            S_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd.comb   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                cmd.o_ld   = (step_reg == bqeq_pkg::STEP_B0);
                if (uses_o)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    step_next  = step_reg + 3'd1;
                    state_next = S_CRD;
                end
            end
            S_WB:
            begin
                cmd.z_wr = 1'b1;
                cmd.z_k  = (step_reg == bqeq_pkg::STEP_A2);
                if (step_reg == bqeq_pkg::STEP_A2)
                begin
                    state_next = S_BEND;
                end
                else
                begin
                    step_next  = step_reg + 3'd1;
                    state_next = S_CRD;
                end
            end
            S_BEND:
            begin
                cmd.s_adv = 1'b1;
                if (stat.last_band)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.band_inc = 1'b1;
                    state_next   = S_ZR1;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= bqeq_pkg::STEP_B0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

/* rtl/bqeq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqeq_datapath
// coefficient and delay memories, shared multiplier, accumulator, output beat
// ----------------------------------------------------------------------------
module bqeq_datapath #(
    parameter int BANDS          = bqeq_pkg::DEF_BANDS,
    parameter int CHANNELS       = bqeq_pkg::DEF_CHANNELS,
    parameter int COEF_FRAC_BITS = bqeq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bqeq_pkg::in_item_t   in_item,
    input  logic                 enable,
    input  logic [15:0]          gain,
    input  bqeq_pkg::cmd_t       cmd,
    output bqeq_pkg::stat_t      stat,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bqeq_pkg::out_item_t  out_item
);

    localparam int NCOEF  = bqeq_pkg::NCOEF;
    localparam int CDEPTH = BANDS * NCOEF;
    localparam int DDEPTH = BANDS * CHANNELS * 2;
    localparam int ROW    = CHANNELS * 2;
    localparam int CA_W   = $clog2(CDEPTH);
    localparam int DA_W   = $clog2(DDEPTH);
    localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;

    logic signed [31:0] coef_mem [CDEPTH];
    logic signed [39:0] delay_mem [DDEPTH];

    logic [DDEPTH-1:0]  dvalid_reg;
    logic [DDEPTH-1:0]  dvalid_next;
    logic [BAND_W-1:0]  band_reg;
    logic               ch_reg;
    logic signed [15:0] sample_reg;
    logic               pass_reg;
    logic signed [31:0] coef_q_reg;
    logic signed [39:0] zq_reg;
    logic               zv_reg;
    logic signed [39:0] z1_reg;
    logic signed [39:0] z2_reg;
    logic signed [39:0] s_reg;
    logic signed [39:0] o_reg;
    logic signed [52:0] prod_reg;
    logic signed [52:0] lo_reg;
    logic signed [39:0] q_reg;
    logic signed [39:0] acc_reg;
    logic signed [39:0] acc_next;
    logic               out_valid_reg;
    bqeq_pkg::out_item_t out_reg;

    logic               coef_ok;
    logic [CA_W-1:0]    coef_wr_addr;
    logic [CA_W-1:0]    coef_rd_addr;
    logic [DA_W-1:0]    z_addr;
    logic signed [39:0] x_val;
    logic signed [20:0] mul_b;
    logic signed [52:0] mul_p;
    logic signed [72:0] full_p;
    logic signed [72:0] shifted_p;
    logic signed [32:0] gain_p;
    logic signed [40:0] rnd_v;
    logic signed [40:0] trunc_v;
    logic signed [15:0] sat_v;

    assign coef_ok = (int'(in_item.band_index) < BANDS)
                     && (in_item.coef_select <= bqeq_pkg::COEF_A2);
    assign coef_wr_addr = CA_W'(CA_W'(in_item.band_index) * CA_W'(NCOEF)
                                + CA_W'(in_item.coef_select));
    assign coef_rd_addr = CA_W'(CA_W'(band_reg) * CA_W'(NCOEF) + CA_W'(cmd.coef_sel));
    assign z_addr = DA_W'(((DA_W'(band_reg) * DA_W'(CHANNELS) + DA_W'(ch_reg)) << 1)
                          + DA_W'(cmd.z_k));

    assign stat.in_req    = (in_item.req_type == bqeq_pkg::REQ_COEF);
    assign stat.in_pass   = !enable || (int'(in_item.channel) >= CHANNELS);
    assign stat.last_band = (band_reg == BAND_W'(BANDS - 1));
    assign stat.out_busy  = out_valid_reg && out_stall;

    assign x_val  = cmd.x_o ? o_reg : s_reg;
    assign mul_b  = cmd.mul_hi ? $signed({x_val[39], x_val[39:20]})
                               : $signed({1'b0, x_val[19:0]});
    assign mul_p  = coef_q_reg * mul_b;
    assign full_p = $signed({prod_reg, 20'b0}) + $signed({{20{lo_reg[52]}}, lo_reg});
    assign shifted_p = full_p >>> COEF_FRAC_BITS;
    assign gain_p = sample_reg * $signed({1'b0, gain});

    assign rnd_v   = $signed({s_reg[39], s_reg}) + (s_reg[39] ? 41'sd65535 : 41'sd0);
    assign trunc_v = rnd_v >>> 16;

    always_comb
    begin
        if (trunc_v > 41'sd32767)
        begin
            sat_v = 16'sd32767;
        end
        else if (trunc_v < -41'sd32768)
        begin
            sat_v = -16'sd32768;
        end
        else
        begin
            sat_v = trunc_v[15:0];
        end
    end

    always_comb
    begin
        case (cmd.acc_op)
            bqeq_pkg::ACC_Q_Z1: acc_next = q_reg + z1_reg;
            bqeq_pkg::ACC_Q_Z2: acc_next = q_reg + z2_reg;
            bqeq_pkg::ACC_SUB:  acc_next = acc_reg - q_reg;
            default:            acc_next = q_reg;
        endcase
    end

    // writing a coefficient drops that band's delays for every channel
    always_comb
    begin
        dvalid_next = dvalid_reg;
        if (cmd.coef_wr && coef_ok)
        begin
            for (int i = 0; i < DDEPTH; i++)
            begin
                if (int'(in_item.band_index) == i / ROW)
                begin
                    dvalid_next[i] = 1'b0;
                end
            end
        end
        if (cmd.z_wr)
        begin
            dvalid_next[z_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dvalid_reg <= dvalid_next;
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.coef_wr && coef_ok)
        begin
            coef_mem[coef_wr_addr] <= in_item.coef_value;
        end
        if (cmd.coef_rd)
        begin
            coef_q_reg <= coef_mem[coef_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.z_wr)
        begin
            delay_mem[z_addr] <= acc_reg;
        end
        if (cmd.z_rd)
        begin
            zq_reg <= delay_mem[z_addr];
            zv_reg <= dvalid_reg[z_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            ch_reg     <= in_item.channel;
            sample_reg <= in_item.sample_in;
            pass_reg   <= stat.in_pass;
        end
        if (cmd.band_clr)
        begin
            band_reg <= '0;
        end
        else if (cmd.band_inc)
        begin
            band_reg <= band_reg + BAND_W'(1);
        end
        if (cmd.gain_ld)
        begin
            s_reg <= {{5{gain_p[32]}}, gain_p, 2'b00};
        end
        else if (cmd.s_adv)
        begin
            s_reg <= o_reg;
        end
        if (cmd.z_cap1)
        begin
            z1_reg <= zv_reg ? zq_reg : 40'sd0;
        end
        if (cmd.z_cap2)
        begin
            z2_reg <= zv_reg ? zq_reg : 40'sd0;
        end
        if (cmd.mul_lo || cmd.mul_hi)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.mul_hi)
        begin
            lo_reg <= prod_reg;
        end
        if (cmd.comb)
        begin
            q_reg <= shifted_p[39:0];
        end
        if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.o_ld)
        begin
            o_reg <= acc_next;
        end
        if (cmd.out_ld)
        begin
            out_reg.sample_out  <= pass_reg ? sample_reg : sat_v;
            out_reg.channel_out <= ch_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

/* rtl/biquad_cascade_equalizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_cascade_equalizer
// multichannel cascade of transposed direct form II biquads with input gain
// ----------------------------------------------------------------------------
// One sample beat is taken at a time. For a filtered sample, every band reads
// its two delays, then runs five coefficient products through one 32 x 21
// multiplier, each product costing a coefficient read, two partial multiplies,
// a recombine and an accumulate, plus two delay writebacks and a band step. A
// pass-through sample (disabled, or channel not kept) skips the bands, and a
// coefficient write beat leaves the sequencer idle. Results wait in an output
// register; a finished sample holds the sequencer until that register is free.
// Delay state resets to zero and a coefficient write zeroes its band's delays
// for all channels.
module biquad_cascade_equalizer #(
    parameter int BANDS          = bqeq_pkg::DEF_BANDS,
    parameter int CHANNELS       = bqeq_pkg::DEF_CHANNELS,
    parameter int COEF_FRAC_BITS = bqeq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bqeq_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bqeq_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);

`include "biquad_cascade_equalizer_macros.svh"

    logic            enable_reg;
    logic [15:0]     gain_reg;
    bqeq_pkg::cmd_t  cmd;
    bqeq_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            gain_reg   <= bqeq_pkg::GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bqeq_pkg::REG_ENABLE: enable_reg <= cfg_data[0];
                bqeq_pkg::REG_GAIN:   gain_reg   <= cfg_data;
                default:              enable_reg <= enable_reg;
            endcase
        end
    end

    bqeq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    bqeq_datapath #(
        .BANDS          (BANDS),
        .CHANNELS       (CHANNELS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_data),
        .enable    (enable_reg),
        .gain      (gain_reg),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_data)
    );

    // a sample beat always occupies the sequencer for the following cycle
    `BQEQ_ASSERT_NEXT(a_sample_busy, clk, rst_n, in_valid && !in_stall && !in_data.req_type, in_stall)
    // a result appears only out of a busy sequencer
    `BQEQ_ASSERT_SAME(a_out_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall))
    // a coefficient write beat leaves the sequencer free
    `BQEQ_ASSERT_NEXT(a_coef_idle, clk, rst_n, in_valid && !in_stall && in_data.req_type, !in_stall)

endmodule

/* dv/biquad_cascade_equalizer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_cascade_equalizer_checker
// watches the sample, result and register channels of the equalizer, keeps
// its own copy of gain, enable, coefficients and per-channel delays, works
// out every expected output sample and compares each result beat with it
// ----------------------------------------------------------------------------
module biquad_cascade_equalizer_checker #(
    parameter int BANDS          = bqeq_pkg::DEF_BANDS,
    parameter int CHANNELS       = bqeq_pkg::DEF_CHANNELS,
    parameter int COEF_FRAC_BITS = bqeq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  bqeq_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  bqeq_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    output int                  errors,
    output int                  pending
);

    logic                eq_enable;
    logic [15:0]         eq_gain;
    logic signed [31:0]  coefs [BANDS][bqeq_pkg::NCOEF];
    logic signed [39:0]  z1 [BANDS][CHANNELS];
    logic signed [39:0]  z2 [BANDS][CHANNELS];
    bqeq_pkg::out_item_t expected_samples [$];

    function automatic logic signed [39:0] coef_mul(logic signed [31:0] a,
                                                    logic signed [39:0] x);
        logic signed [71:0] p;
        p = a * x;
        p = p >>> COEF_FRAC_BITS;
        return p[39:0];
    endfunction

    // runs the cascade on one sample, updating the delays; a disabled or out-of-range channel sample passes through
    function automatic bqeq_pkg::out_item_t filter_sample(bqeq_pkg::in_item_t it);
        logic signed [39:0]  s;
        logic signed [39:0]  o;
        logic signed [40:0]  mag;
        logic signed [40:0]  v;
        bqeq_pkg::out_item_t r;
        r.channel_out = it.channel;
        if (!eq_enable || it.channel >= CHANNELS)
        begin
            r.sample_out = it.sample_in;
            return r;
        end
        s = it.sample_in * $signed({1'b0, eq_gain}) * 4;
        for (int b = 0; b < BANDS; b++)
        begin
            o = coef_mul(coefs[b][bqeq_pkg::COEF_B0], s) + z1[b][it.channel];
            z1[b][it.channel] = coef_mul(coefs[b][bqeq_pkg::COEF_B1], s)
                - coef_mul(coefs[b][bqeq_pkg::COEF_A1], o) + z2[b][it.channel];
            z2[b][it.channel] = coef_mul(coefs[b][bqeq_pkg::COEF_B2], s)
                - coef_mul(coefs[b][bqeq_pkg::COEF_A2], o);
            s = o;
        end
        mag = {s[39], s};
        if (s < 0)
            mag = -mag;
        v = mag >>> 16;
        if (s < 0)
            v = -v;
        if (v > 41'sd32767)
            v = 41'sd32767;
        if (v < -41'sd32768)
            v = -41'sd32768;
        r.sample_out = v[15:0];
        return r;
    endfunction

    assign pending = expected_samples.size();

    always @(posedge clk or negedge rst_n)
    begin
        bqeq_pkg::out_item_t want;
        if (!rst_n)
        begin
            eq_enable = 1'b0;
            eq_gain   = bqeq_pkg::GAIN_RESET;
            for (int b = 0; b < BANDS; b++)
            begin
                for (int k = 0; k < bqeq_pkg::NCOEF; k++)
                    coefs[b][k] = '0;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    z1[b][c] = '0;
                    z2[b][c] = '0;
                end
            end
            expected_samples.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == bqeq_pkg::REG_ENABLE)
                    eq_enable = cfg_data[0];
                else
                    eq_gain = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("result beat with no sample waiting: %0d ch %0d",
                           out_data.sample_out, out_data.channel_out);
                    errors++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (want.sample_out !== out_data.sample_out)
                    begin
                        $error("sample_out expected %0d got %0d",
                               want.sample_out, out_data.sample_out);
                        errors++;
                    end
                    if (want.channel_out !== out_data.channel_out)
                    begin
                        $error("channel_out expected %0d got %0d",
                               want.channel_out, out_data.channel_out);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.req_type == bqeq_pkg::REQ_COEF)
                begin
                    if (in_data.band_index < BANDS
                        && in_data.coef_select < bqeq_pkg::NCOEF)
                    begin
                        coefs[in_data.band_index][in_data.coef_select] =
                            in_data.coef_value;
                        for (int c = 0; c < CHANNELS; c++)
                        begin
                            z1[in_data.band_index][c] = '0;
                            z2[in_data.band_index][c] = '0;
                        end
                    end
                end
                else
                    expected_samples.push_back(filter_sample(in_data));
            end
        end
    end

endmodule

/* dv/biquad_cascade_equalizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_cascade_equalizer_tb
// loads coefficients, runs directed edge samples and phases of random
// samples and coefficient writes under several gain and enable settings and
// idle patterns, including a long output hold-off; a checker compares results
// ----------------------------------------------------------------------------
module biquad_cascade_equalizer_tb;

    localparam int LIMIT       = 4000000;
    localparam int DRAIN       = 400;
    localparam int PHASE_BEATS = 330;
    localparam int BANDS_N     = bqeq_pkg::DEF_BANDS;
    localparam int NCOEF_N     = bqeq_pkg::NCOEF;
    localparam int ITEM_W      = $bits(bqeq_pkg::in_item_t);

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    bqeq_pkg::in_item_t  in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    bqeq_pkg::out_item_t out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = bqeq_pkg::REG_ENABLE;
    logic [15:0]         cfg_data  = '0;

    int errors;
    int pending;
    int cycles    = 0;
    int tx_pct    = 0;
    int rx_pct    = 0;
    logic hold_go = 1'b0;
    int hold_left = 0;

    biquad_cascade_equalizer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    biquad_cascade_equalizer_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_go && hold_left == 0)
        begin
            hold_left <= 3000;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_pct);
    end

    task automatic reg_write(logic idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_beat(bqeq_pkg::in_item_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if ($urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_pct)
                @(posedge clk);
        end
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic bqeq_pkg::in_item_t coef_beat(int band, int sel, logic [31:0] val);
        bqeq_pkg::in_item_t it;
        it = bqeq_pkg::in_item_t'(ITEM_W'({$urandom, $urandom}));
        it.req_type    = bqeq_pkg::REQ_COEF;
        it.band_index  = 4'(band);
        it.coef_select = 3'(sel);
        it.coef_value  = val;
        return it;
    endfunction

    function automatic bqeq_pkg::in_item_t sample_beat(logic ch, logic [15:0] smp);
        bqeq_pkg::in_item_t it;
        it = bqeq_pkg::in_item_t'(ITEM_W'({$urandom, $urandom}));
        it.req_type  = bqeq_pkg::REQ_SAMPLE;
        it.channel   = ch;
        it.sample_in = smp;
        return it;
    endfunction

    // mostly modest filter coefficients, sometimes anything
    function automatic logic [31:0] pick_coef(int sel);
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return $urandom;
        if (sel == bqeq_pkg::COEF_B0 && r < 60)
            return 32'sd268435456 + $signed($urandom_range(0, 1 << 26)) - (1 << 25);
        return $signed($urandom_range(0, 1 << 27)) - (1 << 26);
    endfunction

    function automatic bqeq_pkg::in_item_t random_beat();
        int r;
        int s;
        r = $urandom_range(99);
        if (r < 6)
            return coef_beat($urandom_range(0, BANDS_N - 1),
                             $urandom_range(0, NCOEF_N - 1), 32'd0);
        if (r < 10)
        begin
            if ($urandom_range(1))
                return coef_beat($urandom_range(10, 15), $urandom_range(0, 7),
                                 $urandom);
            return coef_beat($urandom_range(0, 15), $urandom_range(5, 7), $urandom);
        end
        s = $urandom_range(99);
        if (s < 5)
            return sample_beat(1'($urandom_range(1)), 16'h7fff);
        if (s < 10)
            return sample_beat(1'($urandom_range(1)), 16'h8000);
        if (s < 40)
            return sample_beat(1'($urandom_range(1)),
                               16'($urandom_range(0, 255) - 128));
        return sample_beat(1'($urandom_range(1)), 16'($urandom));
    endfunction

    initial
    begin
        bqeq_pkg::in_item_t it;
        logic        ph_en   [6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
        logic [15:0] ph_gain [6] = '{16'd16384, 16'd65535, 16'd65535, 16'd0,
                                     16'd8000, 16'd16384};
        int          ph_tx   [6] = '{0, 62, 0, 17, 62, 0};
        int          ph_rx   [6] = '{0, 0, 62, 17, 0, 62};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load every coefficient, identity-like with some real shaping
        for (int b = 0; b < BANDS_N; b++)
            for (int k = 0; k < NCOEF_N; k++)
                send_beat(coef_beat(b, k, (k == bqeq_pkg::COEF_B0) ? 32'sd268435456
                                          : ((b < 3) ? pick_coef(k) : 32'sd0)));

        // disabled pass-through of the extremes
        send_beat(sample_beat(1'b0, 16'h7fff));
        send_beat(sample_beat(1'b1, 16'h8000));
        go_idle();
        reg_write(bqeq_pkg::REG_ENABLE, 16'd1);
        send_beat(sample_beat(1'b0, 16'h7fff));
        send_beat(sample_beat(1'b1, 16'h8000));
        send_beat(sample_beat(1'b0, 16'h0000));
        send_beat(sample_beat(1'b1, 16'hffff));
        send_beat(coef_beat(10, bqeq_pkg::COEF_B0, $urandom));
        send_beat(coef_beat(15, bqeq_pkg::COEF_A2, $urandom));
        send_beat(coef_beat(2, 5, $urandom));
        send_beat(coef_beat(9, 7, $urandom));
        send_beat(sample_beat(1'b0, 16'h1234));
        go_idle();
        reg_write(bqeq_pkg::REG_GAIN, 16'hffff);
        send_beat(sample_beat(1'b0, 16'h7fff));
        send_beat(sample_beat(1'b1, 16'h8000));
        send_beat(coef_beat(0, bqeq_pkg::COEF_B0, 32'h7fffffff));
        send_beat(sample_beat(1'b0, 16'h4000));
        send_beat(coef_beat(0, bqeq_pkg::COEF_B0, 32'h80000000));
        send_beat(sample_beat(1'b1, 16'h4000));
        send_beat(coef_beat(0, bqeq_pkg::COEF_B0, 32'sd268435456));
        go_idle();
        reg_write(bqeq_pkg::REG_GAIN, 16'd0);
        send_beat(sample_beat(1'b0, 16'h7fff));
        send_beat(sample_beat(1'b1, 16'h8000));
        go_idle();

        for (int p = 0; p < 6; p++)
        begin
            tx_pct = ph_tx[p];
            rx_pct = ph_rx[p];
            reg_write(bqeq_pkg::REG_ENABLE, {15'd0, ph_en[p]});
            reg_write(bqeq_pkg::REG_GAIN, ph_gain[p]);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                it = random_beat();
                if (it.req_type == bqeq_pkg::REQ_COEF && it.band_index < BANDS_N
                    && it.coef_select < NCOEF_N)
                    it.coef_value = pick_coef(it.coef_select);
                if (p == 1 && n == 100)
                    hold_go <= 1'b1;
                else if (p == 1 && n == 101)
                    hold_go <= 1'b0;
                send_beat(it);
            end
            hold_go <= 1'b0;
            go_idle();
        end

        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
